/* sv/spq_pkg.sv */
// Package for the sorted priority task queue.
// Holds operation codes, controller states, cell commands and default sizes.
// No dependencies.
package spq_pkg;

  localparam int QUEUE_DEPTH_DEF   = 16;
  localparam int PAYLOAD_BITS_DEF  = 32;
  localparam int PRIORITY_BITS_DEF = 16;
  localparam int FUNC_BITS         = 3;

  typedef enum logic [FUNC_BITS-1:0] {
    FUNC_APPEND     = 3'd0,
    FUNC_INSERT     = 3'd1,
    FUNC_POP        = 3'd2,
    FUNC_PEEK       = 3'd3,
    FUNC_ITER_FIRST = 3'd4,
    FUNC_ITER_NEXT  = 3'd5,
    FUNC_CLEAR      = 3'd6
  } func_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_APPLY
  } state_e;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_APPEND,
    CELL_INSERT,
    CELL_POP
  } cell_op_e;

  typedef struct packed {
    cell_op_e op;
  } cell_ctrl_t;

endpackage

/* sv/spq_cell.sv */
// One queue slot of the sorted priority task queue chain.
// Holds an entry, an insert-position prefix flag and a read-bus stage.
// Depends on spq_pkg.
module spq_cell import spq_pkg::*; #(
  parameter int IDX           = 0,
  parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEF,
  parameter int PRIORITY_BITS = PRIORITY_BITS_DEF,
  parameter int PAYLOAD_BITS  = PAYLOAD_BITS_DEF
) (
  input  logic                         clk_i,
  input  cell_ctrl_t                   ctrl_i,
  input  logic [$clog2(QUEUE_DEPTH+1)-1:0] count_i,
  input  logic [$clog2(QUEUE_DEPTH)-1:0]   rd_idx_i,
  input  logic [PRIORITY_BITS-1:0]     new_pri_i,
  input  logic [PAYLOAD_BITS-1:0]      new_pay_i,
  input  logic [PRIORITY_BITS-1:0]     prev_pri_i,
  input  logic [PAYLOAD_BITS-1:0]      prev_pay_i,
  input  logic                         prev_hit_i,
  input  logic [PRIORITY_BITS-1:0]     next_pri_i,
  input  logic [PAYLOAD_BITS-1:0]      next_pay_i,
  input  logic [PRIORITY_BITS-1:0]     next_rd_pri_i,
  input  logic [PAYLOAD_BITS-1:0]      next_rd_pay_i,
  output logic [PRIORITY_BITS-1:0]     pri_o,
  output logic [PAYLOAD_BITS-1:0]      pay_o,
  output logic                         hit_o,
  output logic [PRIORITY_BITS-1:0]     rd_pri_o,
  output logic [PAYLOAD_BITS-1:0]      rd_pay_o
);

  localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);
  localparam int IDX_BITS = $clog2(QUEUE_DEPTH);

  logic [PRIORITY_BITS-1:0] pri_q, pri_d;
  logic [PAYLOAD_BITS-1:0]  pay_q, pay_d;
  logic                     hit_q, hit_d;
  logic [PRIORITY_BITS-1:0] rd_pri_q, rd_pri_d;
  logic [PAYLOAD_BITS-1:0]  rd_pay_q, rd_pay_d;
  logic                     occ, at_tail, sel, ins_here;

  assign occ      = CNT_BITS'(IDX) < count_i;
  assign at_tail  = CNT_BITS'(IDX) == count_i;
  assign sel      = rd_idx_i == IDX_BITS'(IDX);
  assign ins_here = (hit_q && !prev_hit_i) || (!hit_q && at_tail);

  always_comb begin
    hit_d    = prev_hit_i | (occ && (new_pri_i > pri_q));
    rd_pri_d = sel ? pri_q : next_rd_pri_i;
    rd_pay_d = sel ? pay_q : next_rd_pay_i;
    pri_d    = pri_q;
    pay_d    = pay_q;
    case (ctrl_i.op)
      CELL_APPEND: begin
        if (at_tail) begin
          pri_d = new_pri_i;
          pay_d = new_pay_i;
        end
      end
      CELL_INSERT: begin
        if (ins_here) begin
          pri_d = new_pri_i;
          pay_d = new_pay_i;
        end else if (hit_q) begin
          pri_d = prev_pri_i;
          pay_d = prev_pay_i;
        end
      end
      CELL_POP: begin
        pri_d = next_pri_i;
        pay_d = next_pay_i;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    pri_q    <= pri_d;
    pay_q    <= pay_d;
    hit_q    <= hit_d;
    rd_pri_q <= rd_pri_d;
    rd_pay_q <= rd_pay_d;
  end

  assign pri_o    = pri_q;
  assign pay_o    = pay_q;
  assign hit_o    = hit_q;
  assign rd_pri_o = rd_pri_q;
  assign rd_pay_o = rd_pay_q;

endmodule

/* sv/sorted_priority_task_queue.sv */
// Top level of the sorted priority task queue: controller and chain of slots.
// Depends on spq_pkg and spq_cell.
//
//   channel | valid       | ready       | payload
//   input   | in_valid_i  | in_ready_o  | func_i, entry_priority_i, entry_payload_i
//   result  | out_valid_o | out_ready_i | ok_o, queue_empty_o, out_priority_o, out_payload_o
//
// Append, pop, peek, iterate first, clear: go from idle to the apply state, which
// waits for a free output register and registers the result. Insert and iterate
// next first pass the sweep state, while the position flag and read bus ripple one slot per cycle.
// Reset clears the entry count, cursor and controller; slots need no clearing.
// A result waits in the output register; the next transaction is accepted
// meanwhile and its update holds until that register is free.
module sorted_priority_task_queue import spq_pkg::*; #(
  parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEF,
  parameter int PAYLOAD_BITS  = PAYLOAD_BITS_DEF,
  parameter int PRIORITY_BITS = PRIORITY_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [FUNC_BITS-1:0]     func_i,
  input  logic [PRIORITY_BITS-1:0] entry_priority_i,
  input  logic [PAYLOAD_BITS-1:0]  entry_payload_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic                     ok_o,
  output logic                     queue_empty_o,
  output logic [PRIORITY_BITS-1:0] out_priority_o,
  output logic [PAYLOAD_BITS-1:0]  out_payload_o
);

  localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);
  localparam int IDX_BITS = $clog2(QUEUE_DEPTH);
  localparam int NXT_BITS = IDX_BITS + 1;

  state_e                   state_q, state_d;
  logic [IDX_BITS-1:0]      sweep_q, sweep_d;
  func_e                    func_q, func_d;
  logic [PRIORITY_BITS-1:0] pri_q, pri_d;
  logic [PAYLOAD_BITS-1:0]  pay_q, pay_d;
  logic [CNT_BITS-1:0]      count_q, count_d;
  logic [IDX_BITS-1:0]      cursor_q, cursor_d;
  logic                     cur_valid_q, cur_valid_d;
  logic                     out_valid_q, out_valid_d;
  logic                     ok_q, ok_d;
  logic                     empty_q, empty_d;
  logic [PRIORITY_BITS-1:0] opri_q, opri_d;
  logic [PAYLOAD_BITS-1:0]  opay_q, opay_d;
  cell_ctrl_t               ctrl;
  logic                     full, empty, out_free;
  logic [NXT_BITS-1:0]      nxt;
  logic [IDX_BITS-1:0]      rd_idx;

  logic [PRIORITY_BITS-1:0] c_pri    [QUEUE_DEPTH];
  logic [PAYLOAD_BITS-1:0]  c_pay    [QUEUE_DEPTH];
  logic                     c_hit    [QUEUE_DEPTH];
  logic [PRIORITY_BITS-1:0] c_rd_pri [QUEUE_DEPTH];
  logic [PAYLOAD_BITS-1:0]  c_rd_pay [QUEUE_DEPTH];

  assign full     = count_q == CNT_BITS'(QUEUE_DEPTH);
  assign empty    = count_q == '0;
  assign nxt      = {1'b0, cursor_q} + NXT_BITS'(1);
  assign rd_idx   = nxt[IDX_BITS-1:0];
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    sweep_d     = sweep_q;
    func_d      = func_q;
    pri_d       = pri_q;
    pay_d       = pay_q;
    count_d     = count_q;
    cursor_d    = cursor_q;
    cur_valid_d = cur_valid_q;
    out_valid_d = out_valid_q && !out_ready_i;
    ok_d        = ok_q;
    empty_d     = empty_q;
    opri_d      = opri_q;
    opay_d      = opay_q;
    ctrl.op     = CELL_HOLD;
    in_ready_o  = state_q == ST_IDLE;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          func_d  = func_e'(func_i);
          pri_d   = entry_priority_i;
          pay_d   = entry_payload_i;
          sweep_d = '0;
          if (func_e'(func_i) == FUNC_INSERT || func_e'(func_i) == FUNC_ITER_NEXT) begin
            state_d = ST_SWEEP;
          end else begin
            state_d = ST_APPLY;
          end
        end
      end
      ST_SWEEP: begin
        sweep_d = sweep_q + IDX_BITS'(1);
        if (sweep_q == IDX_BITS'(QUEUE_DEPTH - 1)) begin
          state_d = ST_APPLY;
        end
      end
      ST_APPLY: begin
        if (out_free) begin
          state_d     = ST_IDLE;
          out_valid_d = 1'b1;
          ok_d        = 1'b0;
          opri_d      = '0;
          opay_d      = '0;
          case (func_q)
            FUNC_APPEND: begin
              if (!full) begin
                ctrl.op = CELL_APPEND;
                count_d = count_q + CNT_BITS'(1);
                ok_d    = 1'b1;
              end
            end
            FUNC_INSERT: begin
              if (!full) begin
                ctrl.op     = CELL_INSERT;
                count_d     = count_q + CNT_BITS'(1);
                cur_valid_d = 1'b0;
                ok_d        = 1'b1;
              end
            end
            FUNC_POP: begin
              if (!empty) begin
                ctrl.op     = CELL_POP;
                count_d     = count_q - CNT_BITS'(1);
                cur_valid_d = 1'b0;
                ok_d        = 1'b1;
                opri_d      = c_pri[0];
                opay_d      = c_pay[0];
              end
            end
            FUNC_PEEK: begin
              if (!empty) begin
                ok_d   = 1'b1;
                opri_d = c_pri[0];
                opay_d = c_pay[0];
              end
            end
            FUNC_ITER_FIRST: begin
              if (!empty) begin
                cursor_d    = '0;
                cur_valid_d = 1'b1;
                ok_d        = 1'b1;
                opri_d      = c_pri[0];
                opay_d      = c_pay[0];
              end
            end
            FUNC_ITER_NEXT: begin
              if (cur_valid_q && (nxt < NXT_BITS'(count_q))) begin
                cursor_d = rd_idx;
                ok_d     = 1'b1;
                opri_d   = c_rd_pri[0];
                opay_d   = c_rd_pay[0];
              end
            end
            FUNC_CLEAR: begin
              count_d     = '0;
              cur_valid_d = 1'b0;
              ok_d        = 1'b1;
            end
            default: begin
            end
          endcase
          empty_d = count_d == '0;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sweep_q     <= '0;
      count_q     <= '0;
      cursor_q    <= '0;
      cur_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sweep_q     <= sweep_d;
      count_q     <= count_d;
      cursor_q    <= cursor_d;
      cur_valid_q <= cur_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q  <= func_d;
    pri_q   <= pri_d;
    pay_q   <= pay_d;
    ok_q    <= ok_d;
    empty_q <= empty_d;
    opri_q  <= opri_d;
    opay_q  <= opay_d;
  end

  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    logic [PRIORITY_BITS-1:0] prev_pri, next_pri, next_rd_pri;
    logic [PAYLOAD_BITS-1:0]  prev_pay, next_pay, next_rd_pay;
    logic                     prev_hit;
    if (g == 0) begin : g_head
      assign prev_pri = '0;
      assign prev_pay = '0;
      assign prev_hit = 1'b0;
    end else begin : g_body
      assign prev_pri = c_pri[g-1];
      assign prev_pay = c_pay[g-1];
      assign prev_hit = c_hit[g-1];
    end
    if (g == QUEUE_DEPTH - 1) begin : g_tail
      assign next_pri    = '0;
      assign next_pay    = '0;
      assign next_rd_pri = '0;
      assign next_rd_pay = '0;
    end else begin : g_link
      assign next_pri    = c_pri[g+1];
      assign next_pay    = c_pay[g+1];
      assign next_rd_pri = c_rd_pri[g+1];
      assign next_rd_pay = c_rd_pay[g+1];
    end
    spq_cell #(
      .IDX           (g),
      .QUEUE_DEPTH   (QUEUE_DEPTH),
      .PRIORITY_BITS (PRIORITY_BITS),
      .PAYLOAD_BITS  (PAYLOAD_BITS)
    ) u_cell (
      .clk_i         (clk_i),
      .ctrl_i        (ctrl),
      .count_i       (count_q),
      .rd_idx_i      (rd_idx),
      .new_pri_i     (pri_q),
      .new_pay_i     (pay_q),
      .prev_pri_i    (prev_pri),
      .prev_pay_i    (prev_pay),
      .prev_hit_i    (prev_hit),
      .next_pri_i    (next_pri),
      .next_pay_i    (next_pay),
      .next_rd_pri_i (next_rd_pri),
      .next_rd_pay_i (next_rd_pay),
      .pri_o         (c_pri[g]),
      .pay_o         (c_pay[g]),
      .hit_o         (c_hit[g]),
      .rd_pri_o      (c_rd_pri[g]),
      .rd_pay_o      (c_rd_pay[g])
    );
  end

  assign out_valid_o    = out_valid_q;
  assign ok_o           = ok_q;
  assign queue_empty_o  = empty_q;
  assign out_priority_o = opri_q;
  assign out_payload_o  = opay_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_BITS'(QUEUE_DEPTH))
    else $error("entry count above queue depth");

  a_cursor_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_valid_q |-> (NXT_BITS'(cursor_q) < NXT_BITS'(count_q)))
    else $error("valid cursor beyond last entry");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !ok_q) |-> (opri_q == '0 && opay_q == '0))
    else $error("failed transaction carries entry data");

  a_hold_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_APPLY && out_valid_q && !out_ready_i) |=> $stable(count_q))
    else $error("queue changed while result stalled");

endmodule
